[src/relay_pulse_mapper_defines.svh]
// Assertion macros shared by the relay pulse mapper checker.
// Expects signals named clk and rst_n in the scope where a macro is used.
`ifndef RELAY_PULSE_MAPPER_DEFINES_SVH
`define RELAY_PULSE_MAPPER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RPM_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RPM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/rpm_pkg.sv]
// Package for the relay pulse mapper: sizes, operation codes, entry types.
// No dependencies; imported by the top level and its checker.
`timescale 1ns / 1ps

package rpm_pkg;

  localparam int RELAYS = 32;
  localparam int PINS   = 32;
  localparam int IDX_W  = $clog2(RELAYS);
  localparam int PIN_W  = 5;
  localparam int MASK_W = 32;
  localparam int CNT_W  = 6;
  localparam int CD_W   = 9;

  // Operation codes of an input word.
  localparam logic [1:0] OP_LOAD    = 2'd0;
  localparam logic [1:0] OP_REQUEST = 2'd1;
  localparam logic [1:0] OP_TICK    = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REQ_WR,
    ST_WALK
  } fsm_t;

  // One relay table entry, 21 bits.
  typedef struct packed {
    logic [PIN_W-1:0] on_pin;
    logic [PIN_W-1:0] off_pin;
    logic             bistable;
    logic             inv_on;
    logic             inv_off;
    logic [7:0]       pulse;
  } relay_entry_t;

  // Dynamic per-relay state, 13 bits.
  typedef struct packed {
    logic            pend_chg;
    logic            pend_lvl;
    logic            cur_lvl;
    logic            pulse_act;
    logic [CD_W-1:0] countdown;
  } relay_state_t;

  typedef struct packed {
    logic [MASK_W-1:0] en;
    logic [MASK_W-1:0] lv;
  } masks_t;

endpackage

[src/relay_pulse_mapper.sv]
// Relay pulse mapper top level: relay table memory, relay state memory, tick walker.
// Depends on rpm_pkg.
`timescale 1ns / 1ps

// A load word is written into the relay table as it is taken; a switch request
// reads the relay state memory as it is taken and writes it back from the
// ST_REQ_WR state. A tick with the lower layer idle walks relays
// 0 .. min(relay_count, 32)-1, one per cycle, reading one table entry and one
// state entry each cycle; its result word is registered after the last relay
// and strobed on out_valid for one cycle (registered from the tick itself when relay_count is 0).
// A busy tick gives no result. The result cannot be held off: the receiver must
// take it in the cycle out_valid is high. busy is high while a request or a walk
// is in progress; configuration may be written only while idle.
module relay_pulse_mapper
  import rpm_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          in_op,
  input  logic [4:0]          in_relay_index,
  input  logic [4:0]          in_on_pin,
  input  logic [4:0]          in_off_pin,
  input  logic                in_is_bistable,
  input  logic                in_invert_on,
  input  logic                in_invert_off,
  input  logic [7:0]          in_pulse_ticks,
  input  logic                in_switch_on,
  input  logic                in_lower_busy,
  output logic                out_valid,
  output logic [MASK_W-1:0]   out_pin_enable,
  output logic [MASK_W-1:0]   out_pin_level,
  output logic                out_io_request,
  input  logic                cfg_we,
  input  logic [CNT_W-1:0]    cfg_wdata
);

  // Writes one pin into the masks; pins outside the pin range are skipped.
  function automatic masks_t drive_pin(masks_t m, logic [PIN_W-1:0] pin, logic level);
    masks_t r;
    r = m;
    if (32'(pin) < PINS) begin
      r.en[pin] = 1'b1;
      r.lv[pin] = level;
    end
    return r;
  endfunction

  fsm_t               state_r, state_nxt;
  logic [CNT_W-1:0]   relay_count_r;
  logic [IDX_W-1:0]   walk_idx_r, walk_idx_nxt;
  logic [IDX_W-1:0]   req_idx_r;
  logic               req_lvl_r;
  masks_t             acc_r, acc_nxt;
  logic               acc_io_r, acc_io_nxt;
  logic               out_valid_r, out_valid_nxt;
  masks_t             out_r, out_nxt;
  logic               out_io_r, out_io_nxt;

  relay_entry_t       tbl_mem [RELAYS];
  relay_entry_t       tbl_rdata_r;
  relay_state_t       st_mem [RELAYS];
  relay_state_t       st_rdata_r;
  logic [RELAYS-1:0]  st_valid_r;
  logic               st_vld_rd_r;

  logic               accept;
  logic [IDX_W-1:0]   rd_addr;
  logic               st_we;
  logic [IDX_W-1:0]   st_waddr;
  relay_state_t       st_wdata;
  logic [CNT_W-1:0]   walk_len;
  logic               walk_last;
  relay_state_t       st_cur;
  relay_state_t       st_new;
  masks_t             walk_m;
  logic               walk_io;
  relay_entry_t       load_entry;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  // Relay count above the table size walks the whole table.
  assign walk_len  = (relay_count_r > CNT_W'(RELAYS)) ? CNT_W'(RELAYS) : relay_count_r;
  assign walk_last = (CNT_W'(walk_idx_r) + CNT_W'(1)) == walk_len;

  assign load_entry = '{on_pin:   in_on_pin,
                        off_pin:  in_off_pin,
                        bistable: in_is_bistable,
                        inv_on:   in_invert_on,
                        inv_off:  in_invert_off,
                        pulse:    in_pulse_ticks};

  // Read address: the requested relay, the next walked relay, or relay zero.
  always_comb begin
    priority if (state_r == ST_WALK) begin
      rd_addr = walk_idx_r + 1'b1;
    end else if (accept && in_op == OP_REQUEST) begin
      rd_addr = in_relay_index[IDX_W-1:0];
    end else begin
      rd_addr = '0;
    end
  end

  // Relay table memory, written by load words.
  always_ff @(posedge clk) begin
    if (accept && in_op == OP_LOAD) begin
      tbl_mem[in_relay_index[IDX_W-1:0]] <= load_entry;
    end
    tbl_rdata_r <= tbl_mem[rd_addr];
  end

  // Relay state memory; an entry that was never written reads as zero.
  always_ff @(posedge clk) begin
    if (st_we) begin
      st_mem[st_waddr] <= st_wdata;
    end
    st_rdata_r <= st_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_valid_r  <= '0;
      st_vld_rd_r <= 1'b0;
    end else begin
      if (st_we) begin
        st_valid_r[st_waddr] <= 1'b1;
      end
      st_vld_rd_r <= st_valid_r[rd_addr];
    end
  end

  assign st_cur = st_vld_rd_r ? st_rdata_r : '0;

  // One relay step: start a pending change, then run the pulse countdown.
  always_comb begin
    walk_m  = acc_r;
    walk_io = acc_io_r;
    st_new  = st_cur;
    if (st_cur.pend_chg) begin
      priority if (st_cur.pend_lvl) begin
        walk_m = drive_pin(walk_m, tbl_rdata_r.on_pin, !tbl_rdata_r.inv_on);
      end else if (tbl_rdata_r.bistable) begin
        walk_m = drive_pin(walk_m, tbl_rdata_r.off_pin, !tbl_rdata_r.inv_off);
      end else begin
        walk_m = drive_pin(walk_m, tbl_rdata_r.on_pin, tbl_rdata_r.inv_on);
      end
      st_new.countdown = {1'b0, tbl_rdata_r.pulse} + CD_W'(1);
      st_new.pulse_act = 1'b1;
      st_new.cur_lvl   = st_cur.pend_lvl;
      st_new.pend_chg  = 1'b0;
      walk_io          = 1'b1;
    end
    if (st_new.pulse_act) begin
      st_new.countdown = st_new.countdown - CD_W'(1);
      if (st_new.countdown == '0) begin
        // Pulse end: a bistable relay releases the coil it last drove.
        if (tbl_rdata_r.bistable) begin
          if (st_new.cur_lvl) begin
            walk_m = drive_pin(walk_m, tbl_rdata_r.on_pin, tbl_rdata_r.inv_on);
          end else begin
            walk_m = drive_pin(walk_m, tbl_rdata_r.off_pin, tbl_rdata_r.inv_off);
          end
          walk_io = 1'b1;
        end
        st_new.pulse_act = 1'b0;
      end
    end
  end

  // Sequencer: next state, memory writes and result word.
  always_comb begin
    state_nxt     = state_r;
    walk_idx_nxt  = walk_idx_r;
    acc_nxt       = acc_r;
    acc_io_nxt    = acc_io_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    out_io_nxt    = out_io_r;
    st_we         = 1'b0;
    st_waddr      = walk_idx_r;
    st_wdata      = st_new;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && in_op == OP_REQUEST) begin
          state_nxt = ST_REQ_WR;
        end else if (accept && in_op == OP_TICK && !in_lower_busy) begin
          walk_idx_nxt = '0;
          acc_nxt      = '0;
          acc_io_nxt   = 1'b0;
          if (walk_len == '0) begin
            out_valid_nxt = 1'b1;
            out_nxt       = '0;
            out_io_nxt    = 1'b0;
          end else begin
            state_nxt = ST_WALK;
          end
        end
      end
      ST_REQ_WR: begin
        st_we             = 1'b1;
        st_waddr          = req_idx_r;
        st_wdata          = st_cur;
        st_wdata.pend_chg = 1'b1;
        st_wdata.pend_lvl = req_lvl_r;
        state_nxt         = ST_IDLE;
      end
      ST_WALK: begin
        st_we      = 1'b1;
        acc_nxt    = walk_m;
        acc_io_nxt = walk_io;
        if (walk_last) begin
          out_valid_nxt = 1'b1;
          out_nxt       = walk_m;
          out_io_nxt    = walk_io;
          state_nxt     = ST_IDLE;
        end else begin
          walk_idx_nxt = walk_idx_r + 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      relay_count_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        relay_count_r <= cfg_wdata;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    walk_idx_r <= walk_idx_nxt;
    acc_r      <= acc_nxt;
    acc_io_r   <= acc_io_nxt;
    out_r      <= out_nxt;
    out_io_r   <= out_io_nxt;
    if (accept && in_op == OP_REQUEST) begin
      req_idx_r <= in_relay_index[IDX_W-1:0];
      req_lvl_r <= in_switch_on;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_pin_enable = out_r.en;
  assign out_pin_level  = out_r.lv;
  assign out_io_request = out_io_r;

endmodule

[src/rpm_checker.sv]
// Port-level checker for the relay pulse mapper, bound to the top level.
// Depends on rpm_pkg and relay_pulse_mapper_defines.svh.
`timescale 1ns / 1ps
`include "relay_pulse_mapper_defines.svh"

module rpm_checker
  import rpm_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic [1:0]        in_op,
  input logic              in_lower_busy,
  input logic              out_valid,
  input logic [MASK_W-1:0] out_pin_enable,
  input logic [MASK_W-1:0] out_pin_level
);

  logic take;
  assign take = start && !busy;

  // A result word is only shown once the walk has finished.
  `RPM_ASSERT_SAME(a_valid_not_busy, out_valid, !busy, "result strobed while busy")

  // A level bit is never set on a pin that is not written.
  `RPM_ASSERT_SAME(a_level_in_enable, out_valid, (out_pin_level & ~out_pin_enable) == '0, "level without enable")

  // A request keeps the block busy while it writes the state memory back from ST_REQ_WR.
  `RPM_ASSERT_NEXT(a_request_busy, take && in_op == OP_REQUEST, busy, "request not interlocked")

  // A load word finishes at once and gives no result.
  `RPM_ASSERT_NEXT(a_load_quiet, take && in_op == OP_LOAD, !busy && !out_valid, "load gave a result")

  // A tick while the lower layer is busy does nothing.
  `RPM_ASSERT_NEXT(a_busy_tick_quiet, take && in_op == OP_TICK && in_lower_busy, !busy && !out_valid, "busy tick gave a result")

endmodule

bind relay_pulse_mapper rpm_checker u_rpm_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .in_op          (in_op),
  .in_lower_busy  (in_lower_busy),
  .out_valid      (out_valid),
  .out_pin_enable (out_pin_enable),
  .out_pin_level  (out_pin_level)
);

[sim/rpm_checker.sv]
`timescale 1ns / 1ps
// Checker for the relay pulse mapper: watches the input, configuration and result
// channels, predicts each result word and compares it field by field.
// Depends on rpm_pkg; instantiated by tb beside the block.

module rpm_tb_checker
  import rpm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  logic [1:0]        in_op,
  input  logic [4:0]        in_relay_index,
  input  logic [4:0]        in_on_pin,
  input  logic [4:0]        in_off_pin,
  input  logic              in_is_bistable,
  input  logic              in_invert_on,
  input  logic              in_invert_off,
  input  logic [7:0]        in_pulse_ticks,
  input  logic              in_switch_on,
  input  logic              in_lower_busy,
  input  logic              out_valid,
  input  logic [MASK_W-1:0] out_pin_enable,
  input  logic [MASK_W-1:0] out_pin_level,
  input  logic              out_io_request,
  input  logic              cfg_we,
  input  logic [CNT_W-1:0]  cfg_wdata,
  output int                errors,
  output int                outstanding
);

  typedef struct packed {
    logic [MASK_W-1:0] en;
    logic [MASK_W-1:0] lv;
    logic              io;
  } pin_word_t;

  // Shadow copy of the relay table, the per-relay state and the relay count.
  relay_entry_t     relay_map [RELAYS];
  logic             pend_chg  [RELAYS];
  logic             pend_lvl  [RELAYS];
  logic             cur_lvl   [RELAYS];
  logic             pulse_act [RELAYS];
  logic [CD_W-1:0]  countdown [RELAYS];
  logic [CNT_W-1:0] walk_count;
  pin_word_t        expected_words [$];

  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $time, msg);
    errors++;
  endtask

  // Pins outside the mask still count toward io_request, so only the masks are guarded.
  task automatic drive_pin(inout logic [MASK_W-1:0] en, inout logic [MASK_W-1:0] lv,
                           input logic [PIN_W-1:0] pin, input logic level);
    if (pin < PINS && pin < MASK_W) begin
      en[pin] = 1'b1;
      lv[pin] = level;
    end
  endtask

  // One tick: walk relays in order, later writes of a shared pin win.
  task automatic walk_relays(output pin_word_t w);
    int               n;
    relay_entry_t     e;
    logic [MASK_W-1:0] en;
    logic [MASK_W-1:0] lv;
    logic             io;
    en = '0;
    lv = '0;
    io = 1'b0;
    n = (walk_count > RELAYS) ? RELAYS : walk_count;
    for (int i = 0; i < n; i++) begin
      e = relay_map[i];
      if (pend_chg[i]) begin
        if (pend_lvl[i]) drive_pin(en, lv, e.on_pin, !e.inv_on);
        else if (e.bistable) drive_pin(en, lv, e.off_pin, !e.inv_off);
        else drive_pin(en, lv, e.on_pin, e.inv_on);
        countdown[i] = CD_W'(e.pulse) + 1'b1;
        pulse_act[i] = 1'b1;
        cur_lvl[i] = pend_lvl[i];
        pend_chg[i] = 1'b0;
        io = 1'b1;
      end
      // The countdown runs on the same tick that loaded it, so a zero pulse
      // time releases the coil right away.
      if (pulse_act[i]) begin
        countdown[i] = countdown[i] - 1'b1;
        if (countdown[i] == '0) begin
          if (e.bistable) begin
            if (cur_lvl[i]) drive_pin(en, lv, e.on_pin, e.inv_on);
            else drive_pin(en, lv, e.off_pin, e.inv_off);
            io = 1'b1;
          end
          pulse_act[i] = 1'b0;
        end
      end
    end
    w.en = en;
    w.lv = lv & en;
    w.io = io;
  endtask

  // Results are checked before a new word is taken: a word accepted at the same
  // edge cannot have its result yet.
  always @(posedge clk) begin
    pin_word_t want;
    pin_word_t made;
    if (!rst_n) begin
      for (int i = 0; i < RELAYS; i++) begin
        relay_map[i] = '0;
        pend_chg[i] = 1'b0;
        pend_lvl[i] = 1'b0;
        cur_lvl[i] = 1'b0;
        pulse_act[i] = 1'b0;
        countdown[i] = '0;
      end
      walk_count = '0;
      expected_words.delete();
    end else begin
      if (out_valid) begin
        if (expected_words.size() == 0) begin
          report_mismatch($sformatf("result word %h/%h/%b with no prediction waiting",
                                    out_pin_enable, out_pin_level, out_io_request));
        end else begin
          want = expected_words.pop_front();
          if (out_pin_enable !== want.en)
            report_mismatch($sformatf("pin_enable %h, expected %h", out_pin_enable, want.en));
          if (out_pin_level !== want.lv)
            report_mismatch($sformatf("pin_level %h, expected %h", out_pin_level, want.lv));
          if (out_io_request !== want.io)
            report_mismatch($sformatf("io_request %b, expected %b", out_io_request, want.io));
        end
      end
      if (cfg_we) walk_count = cfg_wdata;
      if (start && !busy) begin
        case (in_op)
          OP_LOAD: begin
            relay_map[in_relay_index] = '{on_pin: in_on_pin, off_pin: in_off_pin,
                                          bistable: in_is_bistable, inv_on: in_invert_on,
                                          inv_off: in_invert_off, pulse: in_pulse_ticks};
          end
          OP_REQUEST: begin
            pend_chg[in_relay_index] = 1'b1;
            pend_lvl[in_relay_index] = in_switch_on;
          end
          OP_TICK: begin
            if (!in_lower_busy) begin
              walk_relays(made);
              expected_words.push_back(made);
            end
          end
          default: ;
        endcase
      end
    end
    outstanding <= expected_words.size();
  end

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps
// Testbench top for the relay pulse mapper: clock, reset, stimulus and verdict.
// Depends on rpm_pkg, relay_pulse_mapper and rpm_tb_checker.

module tb;
  import rpm_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 40;
  localparam int STALL_LIMIT   = 3000;
  localparam int PHASE_WORDS   = 40;
  localparam int LONG_TICKS    = 262;

  typedef struct packed {
    logic [1:0] op;
    logic [4:0] idx;
    logic [4:0] on_pin;
    logic [4:0] off_pin;
    logic       bist;
    logic       inv_on;
    logic       inv_off;
    logic [7:0] pulse;
    logic       sw;
    logic       lbusy;
  } word_t;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [1:0]        in_op;
  logic [4:0]        in_relay_index;
  logic [4:0]        in_on_pin;
  logic [4:0]        in_off_pin;
  logic              in_is_bistable;
  logic              in_invert_on;
  logic              in_invert_off;
  logic [7:0]        in_pulse_ticks;
  logic              in_switch_on;
  logic              in_lower_busy;
  logic              out_valid;
  logic [MASK_W-1:0] out_pin_enable;
  logic [MASK_W-1:0] out_pin_level;
  logic              out_io_request;
  logic              cfg_we;
  logic [CNT_W-1:0]  cfg_wdata;
  int                errors;
  int                outstanding;
  int                stall_cycles;
  logic              idling;

  relay_pulse_mapper DUT (.*);
  rpm_tb_checker CHK (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: too long without any word moving on a channel means a hang.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || cfg_we) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("tb failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic word_t word_of(input logic [1:0] op, input logic [4:0] idx,
                                    input logic [4:0] on_pin, input logic [4:0] off_pin,
                                    input logic bist, input logic inv_on, input logic inv_off,
                                    input logic [7:0] pulse, input logic sw, input logic lbusy);
    word_t w;
    w = '{op, idx, on_pin, off_pin, bist, inv_on, inv_off, pulse, sw, lbusy};
    return w;
  endfunction

  // Every field is random, unused ones too; pulse times lean short so that
  // pulses end within the run, with a few near the top of the range.
  function automatic word_t random_word(input logic [1:0] op, input logic [4:0] idx);
    word_t w;
    w.op = op;
    w.idx = idx;
    w.on_pin = 5'($urandom_range(0, 31));
    w.off_pin = 5'($urandom_range(0, 31));
    w.bist = 1'($urandom_range(0, 1));
    w.inv_on = 1'($urandom_range(0, 1));
    w.inv_off = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 9))
      0: w.pulse = 8'($urandom_range(250, 255));
      1, 2: w.pulse = 8'($urandom_range(5, 40));
      default: w.pulse = 8'($urandom_range(0, 4));
    endcase
    w.sw = 1'($urandom_range(0, 1));
    w.lbusy = ($urandom_range(0, 7) == 0);
    return w;
  endfunction

  // Holds start high until the block takes the word.
  task automatic send_word(input word_t w);
    in_op <= w.op;
    in_relay_index <= w.idx;
    in_on_pin <= w.on_pin;
    in_off_pin <= w.off_pin;
    in_is_bistable <= w.bist;
    in_invert_on <= w.inv_on;
    in_invert_off <= w.inv_off;
    in_pulse_ticks <= w.pulse;
    in_switch_on <= w.sw;
    in_lower_busy <= w.lbusy;
    start <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  task automatic maybe_gap();
    if (idling && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  // Stops sending until every predicted result word has come back.
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0 || busy);
  endtask

  // Loads, requests and busy ticks leave no result behind, so the block gets
  // a settling pause after the drain before the register changes.
  task automatic set_relay_count(input logic [CNT_W-1:0] value);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mixed traffic: mostly requests and ticks so relays keep pulsing, some
  // reloads, a few unused opcodes and now and then a full drain.
  task automatic mixed_phase(input logic [CNT_W-1:0] count, input int words);
    int pick;
    set_relay_count(count);
    for (int k = 0; k < words; k++) begin
      maybe_gap();
      if (idling && $urandom_range(0, 39) == 0) drain();
      pick = $urandom_range(0, 99);
      if (pick < 20) send_word(random_word(OP_LOAD, 5'($urandom_range(0, 31))));
      else if (pick < 55) send_word(random_word(OP_REQUEST, 5'($urandom_range(0, 31))));
      else if (pick < 95) send_word(random_word(OP_TICK, 5'($urandom_range(0, 31))));
      else send_word(random_word(OP_UNUSED, 5'($urandom_range(0, 31))));
    end
  endtask

  initial begin
    start <= 1'b0;
    in_op <= OP_LOAD;
    in_relay_index <= '0;
    in_on_pin <= '0;
    in_off_pin <= '0;
    in_is_bistable <= 1'b0;
    in_invert_on <= 1'b0;
    in_invert_off <= 1'b0;
    in_pulse_ticks <= '0;
    in_switch_on <= 1'b0;
    in_lower_busy <= 1'b0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    rst_n <= 1'b0;
    idling = 1'b1;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // With the reset relay count a tick walks nothing and reports empty masks.
    send_word(word_of(OP_TICK, 5'd0, 5'd0, 5'd0, 1'b0, 1'b0, 1'b0, 8'd0, 1'b0, 1'b0));

    // Fill the whole table before any tick walks a relay.
    for (int r = 0; r < RELAYS; r++) send_word(random_word(OP_LOAD, 5'(r)));
    set_relay_count(6'd32);

    // Zero pulse time on a bistable relay: drive and release in one tick, both ways.
    send_word(word_of(OP_LOAD, 5'd0, 5'd0, 5'd31, 1'b1, 1'b0, 1'b1, 8'd0, 1'b0, 1'b0));
    send_word(word_of(OP_REQUEST, 5'd0, 5'd0, 5'd0, 1'b0, 1'b0, 1'b0, 8'd0, 1'b1, 1'b0));
    send_word(word_of(OP_TICK, 5'd0, 5'd0, 5'd0, 1'b0, 1'b0, 1'b0, 8'd0, 1'b0, 1'b0));
    send_word(word_of(OP_REQUEST, 5'd0, 5'd0, 5'd0, 1'b0, 1'b0, 1'b0, 8'd0, 1'b0, 1'b0));
    send_word(word_of(OP_TICK, 5'd0, 5'd0, 5'd0, 1'b0, 1'b0, 1'b0, 8'd0, 1'b0, 1'b0));

    // Two monostable relays sharing pin 31 with opposite levels; the later one
    // wins. The last request to relay 31 overwrites the earlier one.
    send_word(word_of(OP_LOAD, 5'd31, 5'd31, 5'd0, 1'b0, 1'b1, 1'b0, 8'd3, 1'b0, 1'b0));
    send_word(word_of(OP_LOAD, 5'd1, 5'd31, 5'd7, 1'b0, 1'b0, 1'b0, 8'd1, 1'b0, 1'b0));
    send_word(word_of(OP_REQUEST, 5'd1, 5'd0, 5'd0, 1'b0, 1'b0, 1'b0, 8'd0, 1'b1, 1'b0));
    send_word(word_of(OP_REQUEST, 5'd31, 5'd0, 5'd0, 1'b0, 1'b0, 1'b0, 8'd0, 1'b0, 1'b0));
    send_word(word_of(OP_REQUEST, 5'd31, 5'd0, 5'd0, 1'b0, 1'b0, 1'b0, 8'd0, 1'b1, 1'b0));
    // A busy tick changes nothing; the following ticks run the monostable pulses out.
    send_word(word_of(OP_TICK, 5'd0, 5'd0, 5'd0, 1'b0, 1'b0, 1'b0, 8'd0, 1'b0, 1'b1));
    repeat (4) send_word(word_of(OP_TICK, 5'd0, 5'd0, 5'd0, 1'b0, 1'b0, 1'b0, 8'd0, 1'b0,
                                 1'b0));
    send_word(word_of(OP_UNUSED, 5'd3, 5'd9, 5'd9, 1'b1, 1'b1, 1'b1, 8'd9, 1'b1, 1'b0));

    // All flags set, longest pulse, switched off through the off pin.
    send_word(word_of(OP_LOAD, 5'd2, 5'd31, 5'd31, 1'b1, 1'b1, 1'b1, 8'd255, 1'b0, 1'b0));
    send_word(word_of(OP_REQUEST, 5'd2, 5'd0, 5'd0, 1'b0, 1'b0, 1'b0, 8'd0, 1'b0, 1'b0));
    send_word(word_of(OP_TICK, 5'd0, 5'd0, 5'd0, 1'b0, 1'b0, 1'b0, 8'd0, 1'b0, 1'b0));
    // Monostable switched off with zero pulse time on pin 0.
    send_word(word_of(OP_LOAD, 5'd5, 5'd0, 5'd0, 1'b0, 1'b0, 1'b0, 8'd0, 1'b0, 1'b0));
    send_word(word_of(OP_REQUEST, 5'd5, 5'd0, 5'd0, 1'b0, 1'b0, 1'b0, 8'd0, 1'b0, 1'b0));
    send_word(word_of(OP_TICK, 5'd0, 5'd0, 5'd0, 1'b0, 1'b0, 1'b0, 8'd0, 1'b0, 1'b0));

    // Longest pulse on relay 0 alone: the release must come on the 256th tick,
    // which an 8-bit countdown would miss. Every pass sends one idle-layer tick;
    // other relays only get reloaded in between.
    set_relay_count(6'd1);
    send_word(word_of(OP_LOAD, 5'd0, 5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
                      1'b1, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 8'd255,
                      1'b0, 1'b0));
    send_word(random_word(OP_REQUEST, 5'd0));
    for (int k = 0; k < LONG_TICKS; k++) begin
      maybe_gap();
      case ($urandom_range(0, 19))
        0: send_word(random_word(OP_LOAD, 5'($urandom_range(1, 31))));
        1: send_word(random_word(OP_UNUSED, 5'($urandom_range(0, 31))));
        default: ;
      endcase
      send_word(word_of(OP_TICK, 5'd0, 5'd0, 5'd0, 1'b0, 1'b0, 1'b0, 8'd0, 1'b0, 1'b0));
    end

    mixed_phase(6'd63, PHASE_WORDS);
    mixed_phase(6'($urandom_range(2, 31)), PHASE_WORDS);
    mixed_phase(6'd0, PHASE_WORDS);
    mixed_phase(6'($urandom_range(33, 62)), PHASE_WORDS);
    idling = 1'b0;
    mixed_phase(6'd32, PHASE_WORDS);

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) $display("tb passed");
    else $display("tb failed");
    $finish;
  end

endmodule
